/* hdl/scpc_pkg.sv */
`default_nettype none

package scpc_pkg;

    // field and cell counter widths, the largest count it may reach, and the reset cell limit
    localparam int IndexBits    = 24;
    localparam int ModuleBits   = 32;
    localparam int ChannelBits  = 16;
    localparam int MaxCellsBits = 16;
    localparam int BoundaryBits = 24;

    localparam longint unsigned IndexMax = (64'd1 << IndexBits) - 64'd1;
    localparam longint unsigned FieldMax = 64'hFF_FFFF;
    localparam logic [IndexBits-1:0] IndexLimit =
        IndexBits'((IndexMax < FieldMax) ? IndexMax : FieldMax);

    localparam logic [MaxCellsBits-1:0] MaxCellsReset = MaxCellsBits'(256);

    // result buffer
    localparam int FifoDepth = 4;
    localparam int PtrBits   = $clog2(FifoDepth);
    localparam int CountBits = $clog2(FifoDepth + 1);

    // input and output stream data widths
    localparam int InDataBits  = 48;
    localparam int OutDataBits = 24;

    typedef struct packed {
        logic [ModuleBits-1:0]  module_id;
        logic [ChannelBits-1:0] channel_pos;
        logic                   event_end;
    } cell_t;

    typedef struct packed {
        logic [BoundaryBits-1:0] boundary_index;
        logic                    failed;
        logic                    run_end;
    } result_t;

    // results produced by one cell, first in r0
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } res_push_t;

endpackage

`default_nettype wire

/* hdl/sorted_cell_partition_cutter_top.sv */
`default_nettype none

// sorted cell partition cutter
// s_ channel: one detector cell per transfer, sorted by module then channel;
//   s_tlast marks the last cell of an event
// m_ channel: partition boundaries; m_tdata is the boundary index, m_tuser
//   flags an error result, m_tlast marks the last result of the event
// cfg channel: writes max_partition_cells, always ready; write only while idle
// a cell's first result reaches the m_ channel through the input register, then the cutter into
//   the result buffer
// throughput: one cell per cycle while the buffer has room; a cell that yields two results
//   (cut plus final count, or opening zero plus final count/error) sends them one at a time
//   through the single result port of the four-entry buffer
// the cutter takes a cell only while the buffer has two free slots, so a
//   stalled receiver backs up through the buffer and the input register to
//   s_tready without losing or repeating results
// reset (aresetn low, synchronous): event state and buffer clear,
//   max_partition_cells returns to 256
module sorted_cell_partition_cutter_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // cell input
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [scpc_pkg::InDataBits-1:0]     s_tdata,   // module_id[31:0], channel_pos[47:32]
    input  wire logic                                s_tlast,   // event_end
    // boundary output
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [scpc_pkg::OutDataBits-1:0]         m_tdata,   // boundary_index[23:0]
    output logic                                     m_tuser,   // failed[0]
    output logic                                     m_tlast,   // run_end
    // configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [scpc_pkg::MaxCellsBits-1:0]   cfg_data   // max_partition_cells
);
    import scpc_pkg::*;

    logic [MaxCellsBits-1:0] max_cells_reg, max_cells_next;
    cell_t     s_cell, cur_cell;
    logic      cell_valid, cell_take, room;
    res_push_t push;
    result_t   m_res;

    // register write is always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        max_cells_next = (cfg_valid && cfg_ready) ? cfg_data : max_cells_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_cells_reg <= MaxCellsReset;
        end else begin
            max_cells_reg <= max_cells_next;
        end
    end

    // unpack the cell transfer
    assign s_cell.module_id   = s_tdata[ModuleBits-1:0];
    assign s_cell.channel_pos = s_tdata[ModuleBits +: ChannelBits];
    assign s_cell.event_end   = s_tlast;

    scpc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cell     (s_cell),
        .cell_valid (cell_valid),
        .cur_cell   (cur_cell),
        .cell_take  (cell_take)
    );

    scpc_cutter u_cut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cell_valid (cell_valid),
        .cur_cell   (cur_cell),
        .cell_take  (cell_take),
        .room       (room),
        .max_cells  (max_cells_reg),
        .push       (push)
    );

    scpc_out_fifo u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (m_res)
    );

    // pack the result transfer
    assign m_tdata = m_res.boundary_index;
    assign m_tuser = m_res.failed;
    assign m_tlast = m_res.run_end;

endmodule

`default_nettype wire

/* hdl/scpc_in_stage.sv */
`default_nettype none

module scpc_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire scpc_pkg::cell_t s_cell,
    output logic                cell_valid,
    output scpc_pkg::cell_t     cur_cell,
    input  wire logic           cell_take
);
    import scpc_pkg::*;

    logic  valid_reg, valid_next;
    cell_t cell_reg;

    assign s_ready    = !valid_reg || cell_take;
    assign cell_valid = valid_reg;
    assign cur_cell   = cell_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (cell_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cell_reg <= s_cell;
        end
    end

endmodule

`default_nettype wire

/* hdl/scpc_cutter.sv */
`default_nettype none

module scpc_cutter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cell_valid,
    input  wire scpc_pkg::cell_t                     cur_cell,
    output logic                                     cell_take,
    input  wire logic                                room,
    input  wire logic [scpc_pkg::MaxCellsBits-1:0]   max_cells,
    output scpc_pkg::res_push_t                      push
);
    import scpc_pkg::*;

    logic [ModuleBits-1:0]  prior_mod_reg, prior_mod_next;
    logic [ChannelBits-1:0] prior_ch_reg, prior_ch_next;
    logic [IndexBits-1:0]   cnt_reg, cnt_next;
    logic [IndexBits-1:0]   win_reg, win_next;
    logic [IndexBits-1:0]   best_reg, best_next;
    logic                   best_ok_reg, best_ok_next;
    logic                   err_hold_reg, err_hold_next;

    logic                   allowed, take_cut;
    logic [IndexBits-1:0]   best_new, span, n_plus;
    logic                   best_ok_new, ovf, full, fail, cut;
    logic                   a_v, b_v, c_v;
    result_t                a_r, b_r, c_r;

    assign cell_take = cell_valid && room;

    always_comb begin
        n_plus   = cnt_reg + IndexBits'(1);
        allowed  = (cur_cell.module_id != prior_mod_reg) ||
                   (({1'b0, prior_ch_reg} + 17'd1) < {1'b0, cur_cell.channel_pos});
        take_cut = (cnt_reg > win_reg) && allowed;
        best_new    = take_cut ? cnt_reg : best_reg;
        best_ok_new = best_ok_reg || take_cut;
        span = cnt_reg - win_reg;
        full = span >= IndexBits'(max_cells);
        ovf  = cnt_reg >= IndexLimit;
        fail = ovf || (full && !best_ok_new);
        cut  = !ovf && full && best_ok_new;

        // opening zero, cut or error, closing count
        a_v = !err_hold_reg && (cnt_reg == '0);
        a_r = '{boundary_index: '0, failed: 1'b0, run_end: 1'b0};
        b_v = err_hold_reg ? cur_cell.event_end : (fail || cut);
        if (err_hold_reg || fail) begin
            b_r = '{boundary_index: '0, failed: 1'b1, run_end: cur_cell.event_end};
        end else begin
            b_r = '{boundary_index: BoundaryBits'(best_new), failed: 1'b0, run_end: 1'b0};
        end
        c_v = !err_hold_reg && !fail && cur_cell.event_end;
        c_r = '{boundary_index: BoundaryBits'(n_plus), failed: 1'b0, run_end: 1'b1};

        push.num = 2'(a_v) + 2'(b_v) + 2'(c_v);
        if (a_v) begin
            push.r0 = a_r;
            push.r1 = b_v ? b_r : c_r;
        end else if (b_v) begin
            push.r0 = b_r;
            push.r1 = c_r;
        end else begin
            push.r0 = c_r;
            push.r1 = c_r;
        end
        if (!cell_take) begin
            push.num = 2'd0;
        end

        prior_mod_next = prior_mod_reg;
        prior_ch_next  = prior_ch_reg;
        cnt_next       = cnt_reg;
        win_next       = win_reg;
        best_next      = best_reg;
        best_ok_next   = best_ok_reg;
        err_hold_next  = err_hold_reg;
        if (cell_take) begin
            if (cur_cell.event_end) begin
                prior_mod_next = '0;
                prior_ch_next  = '0;
                cnt_next       = '0;
                win_next       = '0;
                best_next      = '0;
                best_ok_next   = 1'b0;
                err_hold_next  = 1'b0;
            end else if (!err_hold_reg) begin
                if (fail) begin
                    err_hold_next = 1'b1;
                end else begin
                    prior_mod_next = cur_cell.module_id;
                    prior_ch_next  = cur_cell.channel_pos;
                    cnt_next       = n_plus;
                    best_next      = best_new;
                    best_ok_next   = cut ? 1'b0 : best_ok_new;
                    if (cut) begin
                        win_next = best_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_mod_reg <= '0;
            prior_ch_reg  <= '0;
            cnt_reg       <= '0;
            win_reg       <= '0;
            best_reg      <= '0;
            best_ok_reg   <= 1'b0;
            err_hold_reg  <= 1'b0;
        end else begin
            prior_mod_reg <= prior_mod_next;
            prior_ch_reg  <= prior_ch_next;
            cnt_reg       <= cnt_next;
            win_reg       <= win_next;
            best_reg      <= best_next;
            best_ok_reg   <= best_ok_next;
            err_hold_reg  <= err_hold_next;
        end
    end

`ifndef SYNTHESIS
    // never more than two results for one cell
    assert property (@(posedge aclk) disable iff (!aresetn) push.num != 2'd3)
        else $error("more than two results for one cell");

    // a held error stays silent until the last cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_take && err_hold_reg && !cur_cell.event_end) |-> (push.num == 2'd0))
        else $error("result emitted while error held");

    // error results carry index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0 && push.r0.failed) |-> (push.r0.boundary_index == '0))
        else $error("error result with nonzero index");

    // the window start never passes the cell counter
    assert property (@(posedge aclk) disable iff (!aresetn) win_reg <= cnt_reg)
        else $error("window start beyond cell counter");
`endif

endmodule

`default_nettype wire

/* hdl/scpc_out_fifo.sv */
`default_nettype none

module scpc_out_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire scpc_pkg::res_push_t push,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output scpc_pkg::result_t        m_res
);
    import scpc_pkg::*;

    result_t              buf_reg [FifoDepth];
    logic [PtrBits-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CountBits-1:0] count_reg, count_next;
    logic                 pop;
    logic [PtrBits-1:0]   wr_plus;

    assign m_valid = count_reg != '0;
    assign m_res   = buf_reg[rd_reg];
    assign pop     = m_valid && m_ready;
    assign room    = count_reg <= CountBits'(FifoDepth - 2);
    assign wr_plus = wr_reg + PtrBits'(1);

    always_comb begin
        wr_next    = wr_reg + PtrBits'(push.num);
        rd_next    = pop ? rd_reg + PtrBits'(1) : rd_reg;
        count_next = count_reg + CountBits'(push.num) - CountBits'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            buf_reg[wr_reg] <= push.r0;
        end
        if (push.num == 2'd2) begin
            buf_reg[wr_plus] <= push.r1;
        end
    end

`ifndef SYNTHESIS
    // pushes only land in free slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountBits'(FifoDepth))
        else $error("result buffer overflow");

    // a double push needs two free slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num == 2'd2) |-> room)
        else $error("double push without room");

    // a stalled result stays offered and unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_res)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
